// File: hw/rtl/ggdp_pkg.sv
// Shared types, constants and helper functions for the grid goal direction policy.
// Used by the controller, datapath and top level; depends on nothing else.
`default_nettype none

package ggdp_pkg;

    // Map storage size
    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 32;
    localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam int COORD_W  = 6;
    localparam int COST_W   = COORD_W + 1;
    localparam int DIR_W    = 3;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [COORD_W-1:0] MaxRowsC = COORD_W'(MAX_ROWS);
    localparam logic [COORD_W-1:0] MaxColsC = COORD_W'(MAX_COLS);

    localparam logic [COST_W-1:0] COST_BLOCKED = COST_W'(100);

    // Move codes
    localparam logic [DIR_W-1:0] DIR_NORTH    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_EAST     = 3'd1;
    localparam logic [DIR_W-1:0] DIR_SOUTH    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_WEST     = 3'd3;
    localparam logic [DIR_W-1:0] DIR_GOAL     = 3'd4;
    localparam logic [DIR_W-1:0] DIR_OBSTACLE = 3'd5;

    // Configuration register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [1:0] REG_GRID_COLS = 2'd1;
    localparam logic [1:0] REG_GOAL_ROW  = 2'd2;
    localparam logic [1:0] REG_GOAL_COL  = 2'd3;

    typedef logic [MAX_COLS-1:0] row_t;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               blocked;
    } req_t;

    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic             out_of_range;
    } rsp_t;

    typedef struct packed {
        logic [COORD_W-1:0] grid_rows;
        logic [COORD_W-1:0] grid_cols;
        logic [COORD_W-1:0] goal_row;
        logic [COORD_W-1:0] goal_col;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_north;
        logic rd_south;
        logic load_out;
        logic write_row;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_is_query;
        logic out_free;
    } sts_t;

    function automatic logic [COST_W-1:0] manhattan(
        input logic [COST_W-1:0]  r,
        input logic [COST_W-1:0]  c,
        input logic [COORD_W-1:0] gr,
        input logic [COORD_W-1:0] gc
    );
        logic [COST_W-1:0] gr_x;
        logic [COST_W-1:0] gc_x;
        logic [COST_W-1:0] dr;
        logic [COST_W-1:0] dc;
        gr_x = {1'b0, gr};
        gc_x = {1'b0, gc};
        dr   = (r > gr_x) ? (r - gr_x) : (gr_x - r);
        dc   = (c > gc_x) ? (c - gc_x) : (gc_x - c);
        return dr + dc;
    endfunction

    // Obstacle bit of a row word at a 0-based column; zero when not ok
    function automatic logic row_bit(
        input row_t               row,
        input logic [COORD_W-1:0] idx,
        input logic               ok
    );
        return ok ? row[idx[COL_AW-1:0]] : 1'b0;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ggdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ggdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ggdp_ctrl.sv
// Sequencing state machine for the grid goal direction policy.
// Depends on ggdp_pkg for the command and status structs.
`default_nettype none

module ggdp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    input  wire ggdp_pkg::sts_t sts,
    output      ggdp_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_NORTH = 5'b00010,
        ST_SOUTH = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_stall  = 1'b1;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.req_is_query ? ST_NORTH : ST_WRITE;
                end
            end
            ST_NORTH:
            begin
                cmd.rd_north = 1'b1;
                state_next   = ST_SOUTH;
            end
            ST_SOUTH:
            begin
                cmd.rd_south = 1'b1;
                state_next   = ST_EVAL;
            end
            ST_EVAL:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_row = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/ggdp_datapath.sv
// Datapath: obstacle row memory, row buffers, neighbor evaluation, output register.
// Depends on ggdp_pkg and ggdp_ram.
`default_nettype none

module ggdp_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ggdp_pkg::cmd_t cmd,
    output      ggdp_pkg::sts_t sts,
    input  wire ggdp_pkg::cfg_t cfg,
    input  wire ggdp_pkg::req_t req_data,
    output      logic           rsp_valid,
    input  wire logic           rsp_stall,
    output      ggdp_pkg::rsp_t rsp_data
);

    ggdp_pkg::req_t item_reg;
    ggdp_pkg::row_t center_row_reg;
    ggdp_pkg::row_t north_row_reg;
    logic [ggdp_pkg::ROW_AW-1:0] rd_row_reg;
    logic [ggdp_pkg::MAX_ROWS-1:0] row_valid_reg;
    logic           out_valid_reg;
    ggdp_pkg::rsp_t out_data_reg;

    logic                         rd_en;
    logic [ggdp_pkg::ROW_AW-1:0]  rd_addr;
    ggdp_pkg::row_t               rd_raw;
    ggdp_pkg::row_t               rd_row;
    logic                         wr_en;
    logic [ggdp_pkg::ROW_AW-1:0]  wr_addr;
    ggdp_pkg::row_t               wr_data;

    logic [ggdp_pkg::COORD_W-1:0] r;
    logic [ggdp_pkg::COORD_W-1:0] c;
    logic                         req_row_ok;
    logic                         item_store_ok;
    ggdp_pkg::rsp_t               result;

    assign r = item_reg.cell_row;
    assign c = item_reg.cell_col;

    assign req_row_ok    = (req_data.cell_row != '0) && (req_data.cell_row <= ggdp_pkg::MaxRowsC);
    assign item_store_ok = (r != '0) && (r <= ggdp_pkg::MaxRowsC)
                        && (c != '0) && (c <= ggdp_pkg::MaxColsC);

    // Row read address: center row on accept, then north, then south
    always_comb
    begin
        rd_addr = '0;
        if (cmd.accept)
        begin
            if (req_row_ok)
            begin
                rd_addr = ggdp_pkg::ROW_AW'(req_data.cell_row - 6'd1);
            end
        end
        else if (cmd.rd_north)
        begin
            if ((r >= 6'd2) && (r <= ggdp_pkg::MaxRowsC))
            begin
                rd_addr = ggdp_pkg::ROW_AW'(r - 6'd2);
            end
        end
        else if (cmd.rd_south)
        begin
            if ((r != '0) && (r < ggdp_pkg::MaxRowsC))
            begin
                rd_addr = ggdp_pkg::ROW_AW'(r);
            end
        end
    end

    assign rd_en = cmd.accept | cmd.rd_north | cmd.rd_south;

    // A row never written reads as all free
    assign rd_row = row_valid_reg[rd_row_reg] ? rd_raw : '0;

    assign wr_en   = cmd.write_row & item_store_ok;
    assign wr_addr = ggdp_pkg::ROW_AW'(r - 6'd1);

    always_comb
    begin
        wr_data = rd_row;
        if (item_store_ok)
        begin
            wr_data[ggdp_pkg::COL_AW'(c - 6'd1)] = item_reg.blocked;
        end
    end

    ggdp_ram #(
        .WIDTH (ggdp_pkg::MAX_COLS),
        .DEPTH (ggdp_pkg::MAX_ROWS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req_data;
        end
        if (rd_en)
        begin
            rd_row_reg <= rd_addr;
        end
        if (cmd.rd_north)
        begin
            center_row_reg <= rd_row;
        end
        if (cmd.rd_south)
        begin
            north_row_reg <= rd_row;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Neighbor evaluation; the south row comes straight from the memory
    always_comb
    begin
        logic [ggdp_pkg::COORD_W-1:0] nr;
        logic [ggdp_pkg::COORD_W-1:0] nc;
        logic [ggdp_pkg::COST_W-1:0]  r_x;
        logic [ggdp_pkg::COST_W-1:0]  c_x;
        logic                         col_ok;
        logic                         oor;
        logic                         at_goal;
        logic                         center_blk;
        logic [ggdp_pkg::COST_W-1:0]  cost_n;
        logic [ggdp_pkg::COST_W-1:0]  cost_e;
        logic [ggdp_pkg::COST_W-1:0]  cost_s;
        logic [ggdp_pkg::COST_W-1:0]  cost_w;
        logic [ggdp_pkg::COST_W-1:0]  best;
        logic [ggdp_pkg::DIR_W-1:0]   code;

        nr = (cfg.grid_rows > ggdp_pkg::MaxRowsC) ? ggdp_pkg::MaxRowsC : cfg.grid_rows;
        nc = (cfg.grid_cols > ggdp_pkg::MaxColsC) ? ggdp_pkg::MaxColsC : cfg.grid_cols;
        r_x = {1'b0, r};
        c_x = {1'b0, c};
        col_ok = (c != '0) && (c <= ggdp_pkg::MaxColsC);

        oor     = (r == '0) || (r > nr) || (c == '0) || (c > nc);
        at_goal = (r == cfg.goal_row) && (c == cfg.goal_col);
        center_blk = ggdp_pkg::row_bit(center_row_reg, c - 6'd1, col_ok);

        cost_n = ggdp_pkg::row_bit(north_row_reg, c - 6'd1, col_ok)
               ? ggdp_pkg::COST_BLOCKED
               : ggdp_pkg::manhattan(r_x - 7'd1, c_x, cfg.goal_row, cfg.goal_col);
        cost_e = ggdp_pkg::row_bit(center_row_reg, c, c < ggdp_pkg::MaxColsC)
               ? ggdp_pkg::COST_BLOCKED
               : ggdp_pkg::manhattan(r_x, c_x + 7'd1, cfg.goal_row, cfg.goal_col);
        cost_s = ggdp_pkg::row_bit(rd_row, c - 6'd1, col_ok)
               ? ggdp_pkg::COST_BLOCKED
               : ggdp_pkg::manhattan(r_x + 7'd1, c_x, cfg.goal_row, cfg.goal_col);
        cost_w = ggdp_pkg::row_bit(center_row_reg, c - 6'd2,
                                   (c >= 6'd2) && (c <= ggdp_pkg::MaxColsC))
               ? ggdp_pkg::COST_BLOCKED
               : ggdp_pkg::manhattan(r_x, c_x - 7'd1, cfg.goal_row, cfg.goal_col);

        // first strictly lower cost wins, in north, east, south, west order
        best = ggdp_pkg::COST_BLOCKED;
        code = ggdp_pkg::DIR_NORTH;
        if ((r > 6'd1) && (cost_n < best))
        begin
            best = cost_n;
            code = ggdp_pkg::DIR_NORTH;
        end
        if ((c < nc) && (cost_e < best))
        begin
            best = cost_e;
            code = ggdp_pkg::DIR_EAST;
        end
        if ((r < nr) && (cost_s < best))
        begin
            best = cost_s;
            code = ggdp_pkg::DIR_SOUTH;
        end
        if ((c > 6'd1) && (cost_w < best))
        begin
            code = ggdp_pkg::DIR_WEST;
        end

        result.out_of_range = oor;
        if (oor)
        begin
            result.direction = ggdp_pkg::DIR_OBSTACLE;
        end
        else if (at_goal)
        begin
            result.direction = ggdp_pkg::DIR_GOAL;
        end
        else if (center_blk)
        begin
            result.direction = ggdp_pkg::DIR_OBSTACLE;
        end
        else
        begin
            result.direction = code;
        end
    end

    assign sts.req_is_query = req_data.mode;
    assign sts.out_free     = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/grid_goal_direction_policy.sv
// Top level of the grid goal direction policy: configuration registers,
// controller and datapath. Depends on ggdp_pkg, ggdp_ctrl and ggdp_datapath.
//
// The block keeps a 1-based obstacle map and answers per-cell queries with a
// move code toward the goal: 0 north, 1 east, 2 south, 3 west, 4 goal,
// 5 obstacle, and code 5 with out_of_range set for a cell outside the
// configured grid. A write transaction (mode 0) stores one cell's obstacle
// bit and produces no result; a query transaction (mode 1) produces exactly
// one result. The map is held as one word per row in a single-port-read
// memory, so a query accepts and reads the cell's row, reads the north row,
// reads the south row, then evaluates, and a write reads the row and writes
// it back with the bit changed; the row reads of that one memory port set
// both sequences. A finished result waits in an output
// register, and the next transaction is accepted while it waits; a query
// only stalls in its evaluate cycle if the previous result is still held.
// The map comes out of reset all free through one valid bit per row, with
// no clearing pass. Configuration registers (grid_rows, grid_cols, goal_row,
// goal_col, 6 bits each) sit at byte addresses 0, 4, 8, 12 on the APB port
// and are to be written only while the block is idle.
`default_nettype none

module grid_goal_direction_policy (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ggdp_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ggdp_pkg::APB_DW-1:0]   pwdata,
    output      logic [ggdp_pkg::APB_DW-1:0]   prdata,
    output      logic                          pready,
    // request channel
    input  wire logic                          req_valid,
    output      logic                          req_stall,
    input  wire ggdp_pkg::req_t                req_data,
    // response channel
    output      logic                          rsp_valid,
    input  wire logic                          rsp_stall,
    output      ggdp_pkg::rsp_t                rsp_data
);

    logic [ggdp_pkg::COORD_W-1:0] grid_rows_reg;
    logic [ggdp_pkg::COORD_W-1:0] grid_cols_reg;
    logic [ggdp_pkg::COORD_W-1:0] goal_row_reg;
    logic [ggdp_pkg::COORD_W-1:0] goal_col_reg;

    logic           cfg_write;
    logic [1:0]     reg_index;
    ggdp_pkg::cfg_t cfg;
    ggdp_pkg::cmd_t cmd;
    ggdp_pkg::sts_t sts;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    // Configuration registers: written in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= 6'd32;
            grid_cols_reg <= 6'd32;
            goal_row_reg  <= 6'd1;
            goal_col_reg  <= 6'd1;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                ggdp_pkg::REG_GRID_ROWS: grid_rows_reg <= pwdata[ggdp_pkg::COORD_W-1:0];
                ggdp_pkg::REG_GRID_COLS: grid_cols_reg <= pwdata[ggdp_pkg::COORD_W-1:0];
                ggdp_pkg::REG_GOAL_ROW:  goal_row_reg  <= pwdata[ggdp_pkg::COORD_W-1:0];
                ggdp_pkg::REG_GOAL_COL:  goal_col_reg  <= pwdata[ggdp_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            ggdp_pkg::REG_GRID_ROWS: prdata[ggdp_pkg::COORD_W-1:0] = grid_rows_reg;
            ggdp_pkg::REG_GRID_COLS: prdata[ggdp_pkg::COORD_W-1:0] = grid_cols_reg;
            ggdp_pkg::REG_GOAL_ROW:  prdata[ggdp_pkg::COORD_W-1:0] = goal_row_reg;
            ggdp_pkg::REG_GOAL_COL:  prdata[ggdp_pkg::COORD_W-1:0] = goal_col_reg;
            default: prdata = '0;
        endcase
    end

    assign cfg.grid_rows = grid_rows_reg;
    assign cfg.grid_cols = grid_cols_reg;
    assign cfg.goal_row  = goal_row_reg;
    assign cfg.goal_col  = goal_col_reg;

    // Sequencer: accept, row reads, evaluate or write back
    ggdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Map memory, neighbor evaluation and output register
    ggdp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg       (cfg),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // A write transaction never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !req_data.mode) |=> !$rose(rsp_valid))
    else $error("write transaction produced a result");

    // A query keeps the request channel stalled through its north read, south read and evaluate steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_data.mode) |=> req_stall ##1 req_stall ##1 req_stall)
    else $error("query transaction released the request channel too early");

    // An out-of-range query always reports the obstacle code
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.direction == ggdp_pkg::DIR_OBSTACLE))
    else $error("out-of-range result with a move code");

    // The evaluate step loads only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("held result overwritten");

endmodule

`default_nettype wire
